FILE: src/bm3s_pkg.sv
// shared types and constants for the 3x3 binary morphology stream
`timescale 1ns / 1ps

package bm3s_pkg;

  // frame height limit and the widths that follow from it
  localparam int ROW_LIMIT = 4096;
  localparam int ROW_W     = 12;
  localparam int HEIGHT_W  = 13;

  // one delay-line slot: occupied flag and the binary pixel
  typedef struct packed {
    logic valid;
    logic pix;
  } slot_t;

  // token between cells: present marks an item in this stage
  typedef struct packed {
    logic  present;
    slot_t slot;
  } tok_t;

  // control shared by every pass cell
  typedef struct packed {
    logic                mode;
    logic [HEIGHT_W-1:0] height;
  } cell_ctl_t;

endpackage

FILE: src/bm3s_ifs.sv
// request channel interfaces for pixel input and result output
`timescale 1ns / 1ps

interface bm3s_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink (input valid, input action, input pixel_in, output ready);
endinterface

interface bm3s_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

FILE: src/bm3s_ram.sv
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module bm3s_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 8193
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: src/bm3s_cell.sv
// one morphology pass: line store, 3x3 window and frame position counters
`timescale 1ns / 1ps

module bm3s_cell #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           active,
  input  bm3s_pkg::cell_ctl_t            ctl,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
  input  bm3s_pkg::tok_t                 tok_in,
  output bm3s_pkg::tok_t                 tok_out,
  output logic                           last_out
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RING = 2 * MAX_WIDTH + 1;
  localparam int AW   = $clog2(RING);
  localparam int AX   = AW + 1;
  localparam int SW   = $bits(bm3s_pkg::slot_t);
  localparam int DW   = 3 * SW;
  localparam int RW   = bm3s_pkg::ROW_W;
  localparam int HW   = bm3s_pkg::HEIGHT_W;

  logic [AW-1:0]          wp;
  logic [AW-1:0]          wp_next;
  bm3s_pkg::slot_t        h1;
  bm3s_pkg::slot_t        h2;
  bm3s_pkg::slot_t        cur;
  logic                   take;
  logic [AW-1:0]          raddr_a;
  logic [AW-1:0]          raddr_b;
  logic [DW-1:0]          rd_a;
  logic [DW-1:0]          rd_b;

  logic                   b_present;
  bm3s_pkg::slot_t        b_c0;
  bm3s_pkg::slot_t        b_c1;
  bm3s_pkg::slot_t        b_c2;

  logic [CW-1:0]          col;
  logic [RW-1:0]          row;
  logic [CW-1:0]          col_next;
  logic [RW-1:0]          row_next;

  bm3s_pkg::slot_t        win [3][3];
  logic [2:0]             rok;
  logic [2:0]             cok;
  logic                   acc;
  logic                   hit;
  logic                   last_hit;

  logic                   out_present;
  bm3s_pkg::slot_t        out_slot;

  assign cur  = tok_in.slot;
  assign take = en && active && tok_in.present;

  // ring addresses for ages w and 2w of the item now entering
  always_comb begin
    logic [AX-1:0] wpx;
    logic [AX-1:0] wx;
    logic [AX-1:0] w2x;
    wpx = AX'(wp);
    wx  = AX'(width);
    w2x = wx << 1;
    wp_next = (wp == AW'(RING - 1)) ? '0 : wp + AW'(1);
    if (wpx >= wx) begin
      raddr_a = AW'(wpx - wx);
    end else begin
      raddr_a = AW'(wpx + AX'(RING) - wx);
    end
    if (wpx >= w2x) begin
      raddr_b = AW'(wpx - w2x);
    end else begin
      raddr_b = AW'(wpx + AX'(RING) - w2x);
    end
  end

  // each word holds the slot written with it and the two before
  bm3s_ram #(
    .WIDTH (DW),
    .DEPTH (RING)
  ) u_line (
    .clk     (clk),
    .we      (take),
    .waddr   (wp),
    .wdata   ({cur, h1, h2}),
    .re      (en),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // window rows: top from age 2w, middle from age w, bottom from the taps
  always_comb begin
    win[0][2] = bm3s_pkg::slot_t'(rd_b[DW-1 -: SW]);
    win[0][1] = bm3s_pkg::slot_t'(rd_b[DW-SW-1 -: SW]);
    win[0][0] = bm3s_pkg::slot_t'(rd_b[SW-1:0]);
    win[1][2] = bm3s_pkg::slot_t'(rd_a[DW-1 -: SW]);
    win[1][1] = bm3s_pkg::slot_t'(rd_a[DW-SW-1 -: SW]);
    win[1][0] = bm3s_pkg::slot_t'(rd_a[SW-1:0]);
    win[2][2] = b_c0;
    win[2][1] = b_c1;
    win[2][0] = b_c2;
  end

  always_comb begin
    rok[0] = (row != '0) && (HW'(row) <= ctl.height);
    rok[1] = HW'(row) < ctl.height;
    rok[2] = (HW'(row) + HW'(1)) < ctl.height;
    cok[0] = (col != '0) && (WW'(col) <= width);
    cok[1] = WW'(col) < width;
    cok[2] = (WW'(col) + WW'(1)) < width;
  end

  // erosion starts set and ands, dilation starts clear and ors
  always_comb begin
    acc = ctl.mode;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rok[i] && cok[j] && win[i][j].valid) begin
          if (ctl.mode) begin
            acc = acc & win[i][j].pix;
          end else begin
            acc = acc | win[i][j].pix;
          end
        end
      end
    end
  end

  assign hit      = b_present && win[1][1].valid;
  assign last_hit = (HW'(row) == ctl.height - HW'(1)) && (WW'(col) == width - WW'(1));

  always_comb begin
    col_next = col;
    row_next = row;
    if ((WW'(col) + WW'(1)) >= width) begin
      col_next = '0;
      if ((HW'(row) + HW'(1)) >= ctl.height) begin
        row_next = '0;
      end else begin
        row_next = row + RW'(1);
      end
    end else begin
      col_next = col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      h1          <= '0;
      h2          <= '0;
      b_present   <= 1'b0;
      col         <= '0;
      row         <= '0;
      out_present <= 1'b0;
    end else if (en) begin
      b_present   <= take;
      out_present <= b_present;
      if (take) begin
        wp <= wp_next;
        h1 <= cur;
        h2 <= h1;
      end
      if (hit) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        b_c0 <= cur;
        b_c1 <= h1;
        b_c2 <= h2;
      end
      out_slot.valid <= win[1][1].valid;
      out_slot.pix   <= acc;
      last_out       <= hit && last_hit;
    end
  end

  assign tok_out = '{present: out_present, slot: out_slot};

endmodule

FILE: src/binary_morphology_3x3_stream_top.sv
// top level of the cascaded 3x3 binary dilation / erosion stream
`timescale 1ns / 1ps

// channel     dir  request payload              notes
// in_stream   in   action, pixel_in[7:0]        one raster pixel or flush per request
// out_stream  out  pixel_out, frame_end         at most one result per input request
// apb         in   mode/pass_count/width/height register writes, reads back values
//
// one request is taken per clock unless a result is stalled; each pass cell
// registers a line store read, then evaluates the window into the cell output
// the line store of each cell holds 2*MAX_WIDTH+1 words with one write and
// two reads per cycle, which sets the one request per clock rate
// a result follows its pixel by pass_count*(frame_width+1) requests
// reset clears counters, taps and token flags; line store contents stay as is
// a stalled result freezes the whole cell chain; input is taken in the cycle
// the pending result is taken

module binary_morphology_3x3_stream_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_PASSES = 4
) (
  input  logic               clk,
  input  logic               rst,
  bm3s_in_if.sink            in_stream,
  bm3s_out_if.source         out_stream,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_PASSES + 1);
  localparam int HW = bm3s_pkg::HEIGHT_W;

  // register map, word index in paddr[3:2]
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_PASSES = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  logic          mode;
  logic [2:0]    pass_count;
  logic [12:0]   frame_width;
  logic [12:0]   frame_height;
  logic          cfg_wr;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [PW-1:0] p_eff;

  bm3s_pkg::cell_ctl_t                 ctl;
  bm3s_pkg::tok_t [MAX_PASSES:0]       chain;
  logic [MAX_PASSES-1:0]               last;
  bm3s_pkg::tok_t                      sel_tok;
  logic                                sel_last;
  logic                                advance;

  // apb register file, writes land on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      pass_count   <= 3'd1;
      frame_width  <= 13'd640;
      frame_height <= 13'd480;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE:   mode         <= pwdata[0];
        REG_PASSES: pass_count   <= pwdata[2:0];
        REG_WIDTH:  frame_width  <= pwdata[12:0];
        REG_HEIGHT: frame_height <= pwdata[12:0];
        default:    mode         <= mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = 32'(mode);
      REG_PASSES: prdata = 32'(pass_count);
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // out-of-range register values saturate into the supported range
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (int'(frame_height) > bm3s_pkg::ROW_LIMIT) begin
      h_eff = HW'(bm3s_pkg::ROW_LIMIT);
    end else begin
      h_eff = HW'(frame_height);
    end
    if (pass_count == '0) begin
      p_eff = PW'(1);
    end else if (int'(pass_count) > MAX_PASSES) begin
      p_eff = PW'(MAX_PASSES);
    end else begin
      p_eff = PW'(pass_count);
    end
  end

  assign ctl = '{mode: mode, height: h_eff};

  // whole chain moves together unless a result is waiting
  assign advance         = !out_stream.valid || out_stream.ready;
  assign in_stream.ready = advance;

  // a flush enters as a present but empty slot
  assign chain[0] = '{present: in_stream.valid,
                      slot: '{valid: !in_stream.action, pix: |in_stream.pixel_in}};

  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_cell
    bm3s_cell #(
      .MAX_WIDTH (MAX_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .active   (int'(p_eff) > s),
      .ctl      (ctl),
      .width    (w_eff),
      .tok_in   (chain[s]),
      .tok_out  (chain[s+1]),
      .last_out (last[s])
    );
  end

  // results leave from the last enabled pass
  always_comb begin
    sel_tok  = '0;
    sel_last = 1'b0;
    for (int s = 0; s < MAX_PASSES; s++) begin
      if (int'(p_eff) == s + 1) begin
        sel_tok  = chain[s+1];
        sel_last = last[s];
      end
    end
  end

  assign out_stream.valid     = sel_tok.present && sel_tok.slot.valid;
  assign out_stream.pixel_out = sel_tok.slot.pix;
  assign out_stream.frame_end = sel_last;

`ifndef SYNTHESIS
  // a waiting result must freeze every cell output
  a_stall_freezes_chain : assert property (@(posedge clk) disable iff (rst)
    (out_stream.valid && !out_stream.ready) |=> $stable(chain[MAX_PASSES:1]))
    else $error("cell chain moved while a result was stalled");

  // an accepted request moves through b_present into the first cell output as the chain advances
  a_first_cell_latency : assert property (@(posedge clk) disable iff (rst)
    (in_stream.valid && in_stream.ready) ##1 advance |=> chain[1].present)
    else $error("request lost in the first pass cell");
`endif

endmodule

FILE: verif/binary_morphology_3x3_stream_top_test.sv
// self-checking testbench for the cascaded 3x3 binary dilation / erosion stream
`timescale 1ns / 1ps

module binary_morphology_3x3_stream_top_test;

  // block geometry, matches the instance parameters below; narrow rows keep
  // the line stores and the flush tails short
  localparam int MAX_W       = 32;
  localparam int MAX_P       = 4;
  // the window of one pass reaches back 2*width+2 requests, plus the newest one
  localparam int RING_LEN    = 2 * MAX_W + 3;
  // words in one line store of the block
  localparam int LINE_WORDS  = 2 * MAX_W + 1;
  // empties written after a phase so the next phase never sees stale pixels
  localparam int CLEAR_SMALL = 2 * 16 + 3;
  localparam int CLEAR_WIDE  = 2 * MAX_W + 3;
  // wait through the registers of every pass cell plus margin, used once the chain should be empty
  localparam int SETTLE      = 4 * MAX_P + 8;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic {ACT_PIXEL = 1'b0, ACT_FLUSH = 1'b1} action_e;
  typedef enum logic [1:0] {REG_MODE, REG_PASSES, REG_WIDTH, REG_HEIGHT} reg_idx_e;

  // one pending input request; hold makes the sender wait for all results
  typedef struct packed {
    logic       hold;
    action_e    action;
    logic [7:0] pixel;
  } pix_req_t;

  typedef struct packed {
    logic pix;
    logic fend;
  } morph_res_t;

  logic clk;
  logic rst = 1'b1;

  // driven copies of every block input, known from time zero
  logic        drv_valid  = 1'b0;
  logic        drv_action = 1'b0;
  logic [7:0]  drv_pixel  = 8'h00;
  logic        take_ready = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [3:0]  paddr      = 4'h0;
  logic [31:0] pwdata     = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  bm3s_in_if  in_if ();
  bm3s_out_if out_if ();

  assign in_if.valid    = drv_valid;
  assign in_if.action   = drv_action;
  assign in_if.pixel_in = drv_pixel;
  assign out_if.ready   = take_ready;

  binary_morphology_3x3_stream_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_PASSES(MAX_P)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_if),
    .out_stream(out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // the line stores power up holding empty slots, as the predictor rings do
  for (genvar s = 0; s < MAX_P; s++) begin : g_line_init
    initial begin
      for (int i = 0; i < LINE_WORDS; i++) dut.g_cell[s].u_cell.u_line.mem[i] = '0;
    end
  end

  // request queues and bookkeeping
  pix_req_t   pending_reqs[$];
  morph_res_t owed_results[$];
  logic       in_took      = 1'b0;
  int         fail_count   = 0;
  int         cycle_count  = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // predictor state: per-pass delay ring, write pointer and frame position
  bm3s_pkg::slot_t ring_store[MAX_P][RING_LEN];
  int    ring_wr[MAX_P];
  int    pos_col[MAX_P];
  int    pos_row[MAX_P];
  logic  cfg_mode   = 1'b0;
  int    cfg_passes = 1;
  int    cfg_width  = 640;
  int    cfg_height = 480;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic clear_morph_state();
    for (int s = 0; s < MAX_P; s++) begin
      for (int i = 0; i < RING_LEN; i++) ring_store[s][i] = '0;
      ring_wr[s] = 0;
      pos_col[s] = 0;
      pos_row[s] = 0;
    end
  endtask

  // one pass: store the incoming slot, evaluate the window around the centre
  task automatic morph_stage(input int s, input bm3s_pkg::slot_t din, input int w,
                             input int h, output bm3s_pkg::slot_t dout,
                             output logic last_pix);
    int    wp;
    int    cp;
    int    r;
    int    c;
    int    off;
    bm3s_pkg::slot_t nb;
    logic  acc;
    wp = ring_wr[s];
    ring_store[s][wp] = din;
    cp = (wp + RING_LEN - (w + 1)) % RING_LEN;
    dout = '0;
    last_pix = 1'b0;
    // an empty centre (flush or not yet filled) gives nothing
    if (ring_store[s][cp].valid) begin
      r = pos_row[s];
      c = pos_col[s];
      acc = cfg_mode;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          // neighbours outside the frame are skipped, as are empty slots
          if (r + dr >= 0 && r + dr < h && c + dc >= 0 && c + dc < w) begin
            off = w + 1 - dr * w - dc;
            nb = ring_store[s][(wp + RING_LEN - off) % RING_LEN];
            if (nb.valid) acc = cfg_mode ? (acc & nb.pix) : (acc | nb.pix);
          end
        end
      end
      last_pix = (r == h - 1) && (c == w - 1);
      // counters past a shrunk frame wrap at their next advance
      if (c + 1 >= w) begin
        pos_col[s] = 0;
        pos_row[s] = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        pos_col[s] = c + 1;
      end
      dout.valid = 1'b1;
      dout.pix = acc;
    end
    ring_wr[s] = (wp + 1) % RING_LEN;
  endtask

  // push one accepted request through the active passes
  task automatic morph_predict(input logic action, input logic [7:0] pixel);
    int              w;
    int              h;
    int              p;
    bm3s_pkg::slot_t code;
    logic            last_pix;
    morph_res_t      res;
    w = clamp_int(cfg_width, 1, MAX_W);
    h = clamp_int(cfg_height, 1, bm3s_pkg::ROW_LIMIT);
    p = clamp_int(cfg_passes, 1, MAX_P);
    code = (action == ACT_FLUSH) ? bm3s_pkg::slot_t'('0)
                                 : bm3s_pkg::slot_t'{valid: 1'b1, pix: (pixel != 8'h00)};
    last_pix = 1'b0;
    // passes beyond the active count are left untouched
    for (int s = 0; s < p; s++) morph_stage(s, code, w, h, code, last_pix);
    if (code.valid) begin
      res.pix = code.pix;
      res.fend = last_pix;
      owed_results.push_back(res);
    end
  endtask

  // input acceptance, prediction and result checking, all on the rising edge
  always @(posedge clk) begin
    morph_res_t want;
    in_took <= in_if.valid && in_if.ready && !rst;
    if (!rst) begin
      if (in_if.valid && in_if.ready) morph_predict(in_if.action, in_if.pixel_in);
      if (out_if.valid && out_if.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result pixel_out=%0b frame_end=%0b with nothing owed",
                                    out_if.pixel_out, out_if.frame_end));
        end else begin
          want = owed_results.pop_front();
          if (out_if.pixel_out !== want.pix)
            report_mismatch($sformatf("pixel_out got %0b want %0b", out_if.pixel_out, want.pix));
          if (out_if.frame_end !== want.fend)
            report_mismatch($sformatf("frame_end got %0b want %0b", out_if.frame_end, want.fend));
        end
      end
    end
  end

  // request driver and result taker, both move on the falling edge
  always @(negedge clk) begin
    pix_req_t nxt;
    if (rst) begin
      drv_valid <= 1'b0;
      take_ready <= 1'b0;
    end else begin
      if (!drv_valid || in_took) begin
        // a held request waits until every owed result has been taken
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(pending_reqs[0].hold && owed_results.size() != 0)) begin
          nxt = pending_reqs.pop_front();
          drv_valid <= 1'b1;
          drv_action <= nxt.action;
          drv_pixel <= nxt.pixel;
        end else begin
          drv_valid <= 1'b0;
        end
      end
      take_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one register access: setup cycle, then access cycle until pready
  task automatic apb_access(input reg_idx_e idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= 4'(int'(idx) * 4);
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, mirror it in the predictor and read it back
  task automatic set_register(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] rdata;
    apb_access(idx, 1'b1, value, rdata);
    case (idx)
      REG_MODE:   cfg_mode = value[0];
      REG_PASSES: cfg_passes = int'(value[2:0]);
      REG_WIDTH:  cfg_width = int'(value[12:0]);
      REG_HEIGHT: cfg_height = int'(value[12:0]);
    endcase
    apb_access(idx, 1'b0, 32'h0, rdata);
    if (rdata != value)
      report_mismatch($sformatf("%s read back %0d after writing %0d", idx.name(), rdata, value));
  endtask

  task automatic configure(input logic m, input int p, input int w, input int h);
    set_register(REG_MODE, 32'(m));
    set_register(REG_PASSES, 32'(p));
    set_register(REG_WIDTH, 32'(w));
    set_register(REG_HEIGHT, 32'(h));
  endtask

  task automatic push_req(input action_e a, input logic [7:0] pixel);
    pix_req_t r;
    r.hold = 1'b0;
    r.action = a;
    r.pixel = pixel;
    pending_reqs.push_back(r);
  endtask

  // raster frames with a random fill density and the odd stray flush
  task automatic queue_frames(input int frames, input int frame_len);
    int dens;
    for (int f = 0; f < frames; f++) begin
      dens = $urandom_range(0, 100);
      for (int i = 0; i < frame_len; i++) begin
        if ($urandom_range(0, 49) == 0) push_req(ACT_FLUSH, 8'($urandom));
        push_req(ACT_PIXEL,
                 (int'($urandom_range(0, 99)) < dens) ? 8'($urandom_range(1, 255)) : 8'h00);
      end
    end
  endtask

  // flush out the tail, wipe the window for the next phase, wait until idle
  task automatic close_phase(input int clear_len);
    int tail;
    tail = clamp_int(cfg_passes, 1, MAX_P) * (clamp_int(cfg_width, 1, MAX_W) + 1) + clear_len;
    repeat (tail) push_req(ACT_FLUSH, 8'($urandom));
    while (pending_reqs.size() != 0 || drv_valid || owed_results.size() != 0) @(posedge clk);
    // flush requests give no result and may still sit in the cell chain
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(input logic m, input int p, input int w, input int h,
                              input int frames, input int frame_len, input int clear_len);
    configure(m, p, w, h);
    queue_frames(frames, frame_len);
    // somewhere in the phase the sender drains the block before going on
    pending_reqs[$urandom_range(0, pending_reqs.size() - 1)].hold = 1'b1;
    close_phase(clear_len);
  endtask

  initial begin
    clear_morph_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver stalls most of the time
    send_idle_pct = 28;
    recv_idle_pct = 87;

    // dilation, one pass, smallest frame; stream start, a flush inside the frame
    configure(1'b0, 1, 3, 3);
    push_req(ACT_PIXEL, 8'h00);
    push_req(ACT_PIXEL, 8'hFF);
    push_req(ACT_PIXEL, 8'h00);
    push_req(ACT_FLUSH, 8'hA5);
    push_req(ACT_PIXEL, 8'h00);
    push_req(ACT_PIXEL, 8'h00);
    push_req(ACT_PIXEL, 8'h00);
    push_req(ACT_PIXEL, 8'h00);
    push_req(ACT_PIXEL, 8'h00);
    push_req(ACT_PIXEL, 8'h01);
    close_phase(CLEAR_SMALL);

    // erosion over all four passes, one clear pixel spreads through the frame
    configure(1'b1, 4, 3, 3);
    push_req(ACT_PIXEL, 8'h02);
    push_req(ACT_PIXEL, 8'h04);
    push_req(ACT_PIXEL, 8'h08);
    push_req(ACT_PIXEL, 8'h10);
    push_req(ACT_PIXEL, 8'h20);
    push_req(ACT_PIXEL, 8'h40);
    push_req(ACT_PIXEL, 8'h80);
    push_req(ACT_PIXEL, 8'hFE);
    push_req(ACT_PIXEL, 8'h00);
    close_phase(CLEAR_SMALL);

    // random whole frames over a spread of settings
    random_phase(1'b0, 1, 8, 6, 2, 8 * 6, CLEAR_SMALL);
    random_phase(1'b1, 2, 5, 7, 2, 5 * 7, CLEAR_SMALL);

    // now the sender is the slow side
    send_idle_pct = 87;
    recv_idle_pct = 28;
    random_phase(1'b0, 3, 3, 3, 10, 3 * 3, CLEAR_SMALL);
    random_phase(1'b1, 4, 12, 4, 1, 12 * 4, CLEAR_SMALL);
    random_phase(1'b0, 2, 16, 3, 1, 16 * 3, CLEAR_SMALL);
    random_phase(1'b0, 4, 7, 5, 2, 7 * 5, CLEAR_SMALL);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(1'b1, 3, 10, 10, 1, 10 * 10, CLEAR_SMALL);
    // tallest frame, only its first rows; the widest frame follows so clear a full window
    random_phase(1'b1, 1, 3, bm3s_pkg::ROW_LIMIT, 1, 60, CLEAR_WIDE);
    // widest rows, part of the first row; counters arrive out of range and wrap
    random_phase(1'b0, 1, MAX_W, 3, 1, 24, 0);

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: binary_morphology_3x3_stream_top.f
src/bm3s_pkg.sv
src/bm3s_ifs.sv
src/bm3s_ram.sv
src/bm3s_cell.sv
src/binary_morphology_3x3_stream_top.sv
verif/binary_morphology_3x3_stream_top_test.sv
